// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file rv32x_checker.sv.
// Include guard keeps a second inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== hdl/rv32x_pkg.sv =====
// Package for the RV32 subset executor: payload structs, opcodes, command types.
// Used by the controller, the datapath, the top level, the checker and the testbench.
package rv32x_pkg;

  localparam int DataWords = 1024;
  localparam int DataAw = $clog2(DataWords);

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpLui    = 7'h37;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;
  localparam logic [6:0] F7Mul  = 7'h01;

  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Srl  = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [2:0] F3Word = 3'd2;
  localparam logic [2:0] F3Mulh = 3'd1;
  localparam logic [2:0] F3Div  = 3'd4;
  localparam logic [2:0] F3Rem  = 3'd6;

  localparam logic [31:0] ResetPc = 32'h0000_1000;
  localparam logic [0:0] RegStartPc = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [31:0] preload_address;
    logic [31:0] preload_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic        unknown_opcode;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch input word, read operands
    logic mem_read;  // issue data memory read for lw
    logic div_start; // start divider
    logic mul_lo;    // first multiply step
    logic mul_hi;    // second multiply step
    logic finish;    // commit state and form result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_div;
    logic is_mul;
    logic is_load;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/rv32x_divider.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its ports; sign handling is done by the caller.
module rv32x_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] quo;
  logic [31:0] rem_acc;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  // Shift in one dividend bit, try subtract
  always_comb begin
    shifted = {rem_acc, quo[31]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend;
      rem_acc <= '0;
      dvs     <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem_acc <= trial[31:0];
        quo     <= {quo[30:0], 1'b1};
      end else begin
        rem_acc <= shifted[31:0];
        quo     <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem_acc;

endmodule

// ===== hdl/rv32x_datapath.sv =====
// Datapath: pc, register file, data memory, ALU, multiplier and divider.
// Depends on rv32x_pkg and rv32x_divider; steered by rv32x_ctrl commands.
module rv32x_datapath
  import rv32x_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  in_word_t          in_word,
  input  dp_cmd_t           cmd,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              clr_en,
  input  logic [DataAw-1:0] clr_addr,
  output dp_status_t        status,
  output out_word_t         result,
  output logic [31:0]       start_pc
);

  logic [31:0] pc;
  logic [31:0] regs [32];
  logic [31:0] dmem [DataWords];
  logic [31:0] dmem_rd;

  in_word_t    cur;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] ma;
  logic [31:0] mb;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] ins;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  logic        div_go;
  logic        div_done;
  logic [31:0] quo, remd;
  logic        neg_a, neg_b;

  logic [31:0] p_ll, p_lh, p_hl;
  logic [31:0] a_abs, b_abs;

  logic        wr;
  logic [31:0] wval;
  logic        st;
  logic [31:0] saddr;
  logic [31:0] npc;
  logic        unk;
  logic        take;
  logic        lt_s, lt_u;
  logic [31:0] div_val;
  logic [63:0] mulh_full;
  logic [63:0] mag_prod;
  out_word_t   res_next;

  assign ins = cur.instruction;
  assign op  = ins[6:0];
  assign rd  = ins[11:7];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];

  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'h000};

  // Capture input word and operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= in_word;
      a   <= regs[in_word.instruction[19:15]];
      b   <= regs[in_word.instruction[24:20]];
    end
  end

  // Data memory: one write port, one registered read port; zero it during the clear pass
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      dmem_rd <= dmem[DataAw'((a + imm_i) >> 2)];
    end
    if (clr_en) begin
      dmem[clr_addr] <= '0;
    end else if (cmd.finish && cur.mode) begin
      dmem[DataAw'(cur.preload_address >> 2)] <= cur.preload_data;
    end else if (cmd.finish && st) begin
      dmem[DataAw'(saddr >> 2)] <= b;
    end
  end

  // Signed magnitudes for mulh and div
  assign neg_a = a[31];
  assign neg_b = b[31];
  assign a_abs = neg_a ? (32'd0 - a) : a;
  assign b_abs = neg_b ? (32'd0 - b) : b;

  // Multiply in 16-bit partial products over two steps
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      ma   <= (f3 == F3Mulh) ? a_abs : a;
      mb   <= (f3 == F3Mulh) ? b_abs : b;
    end
  end

  logic [31:0] pp0, pp1, pp2, pp3;
  logic [31:0] r_pp0, r_pp1, r_pp2, r_pp3;
  assign pp0 = ma[15:0] * mb[15:0];
  assign pp1 = ma[15:0] * mb[31:16];
  assign pp2 = ma[31:16] * mb[15:0];
  assign pp3 = ma[31:16] * mb[31:16];
  assign p_ll = r_pp0;
  assign p_lh = r_pp1;
  assign p_hl = r_pp2;

  always_ff @(posedge clk) begin
    if (cmd.mul_hi) begin
      r_pp0 <= pp0;
      r_pp1 <= pp1;
      r_pp2 <= pp2;
      r_pp3 <= pp3;
    end
  end

  assign mag_prod = {r_pp3, p_ll} + {16'd0, p_lh, 16'd0} + {16'd0, p_hl, 16'd0};
  assign mulh_full = (neg_a ^ neg_b) ? (64'd0 - mag_prod) : mag_prod;

  // Divider on magnitudes
  assign div_go = cmd.div_start;
  rv32x_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (a_abs),
    .divisor   (b_abs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (remd)
  );

  // Apply RISC-V rules for zero divisor and sign
  always_comb begin
    if (b == 32'd0) begin
      div_val = (f3 == F3Rem) ? a : 32'hFFFF_FFFF;
    end else if (f3 == F3Rem) begin
      div_val = neg_a ? (32'd0 - remd) : remd;
    end else begin
      div_val = (neg_a ^ neg_b) ? (32'd0 - quo) : quo;
    end
  end

  assign lt_s = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
  assign lt_u = a < b;

  // Decode and execute
  always_comb begin
    wr    = 1'b0;
    wval  = '0;
    st    = 1'b0;
    saddr = '0;
    unk   = 1'b0;
    take  = 1'b0;
    npc   = pc + 32'd4;
    case (op)
      OpReg: begin
        if (f7 == F7Base) begin
          wr = 1'b1;
          case (f3)
            F3Add:  wval = a + b;
            F3Sll:  wval = a << b[4:0];
            F3Slt:  wval = {31'd0, lt_s};
            F3Sltu: wval = {31'd0, lt_u};
            F3Xor:  wval = a ^ b;
            F3Srl:  wval = a >> b[4:0];
            F3Or:   wval = a | b;
            default: wval = a & b;
          endcase
        end else if (f7 == F7Alt) begin
          if (f3 == F3Add) begin
            wr = 1'b1; wval = a - b;
          end else if (f3 == F3Srl) begin
            wr = 1'b1; wval = 32'($signed(a) >>> b[4:0]);
          end
        end else if (f7 == F7Mul) begin
          if (f3 == F3Add) begin
            wr = 1'b1; wval = mag_prod[31:0];
          end else if (f3 == F3Mulh) begin
            wr = 1'b1; wval = mulh_full[63:32];
          end else if (f3 == F3Div || f3 == F3Rem) begin
            wr = 1'b1; wval = div_val;
          end
        end
      end
      OpImm: begin
        if (f3 == F3Add) begin
          wr = 1'b1; wval = a + imm_i;
        end
      end
      OpLoad: begin
        if (f3 == F3Word) begin
          wr = 1'b1; wval = dmem_rd;
        end
      end
      OpStore: begin
        if (f3 == F3Word) begin
          st = 1'b1; saddr = a + imm_s;
        end
      end
      OpBranch: begin
        case (f3)
          F3Beq:  take = a == b;
          F3Bne:  take = a != b;
          F3Blt:  take = lt_s;
          F3Bge:  take = !lt_s;
          F3Bltu: take = lt_u;
          F3Bgeu: take = !lt_u;
          default: take = 1'b0;
        endcase
        if (take) npc = pc + imm_b;
      end
      OpJal: begin
        wr = 1'b1; wval = pc + 32'd4; npc = pc + imm_j;
      end
      OpJalr: begin
        wr = 1'b1; wval = pc + 32'd4; npc = (a + imm_i) & 32'hFFFF_FFFE;
      end
      OpAuipc: begin
        wr = 1'b1; wval = pc + imm_u;
      end
      OpLui: begin
        wr = 1'b1; wval = imm_u;
      end
      default: unk = 1'b1;
    endcase
  end

  // Commit pc; a configuration write loads pc and start_pc
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ResetPc;
      start_pc <= ResetPc;
    end else if (cfg_we) begin
      pc <= cfg_data;
      start_pc <= cfg_data;
    end else if (cmd.finish && !cur.mode) begin
      pc <= npc;
    end
  end

  // Register file with reset clear (32 entries)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else if (cmd.finish && !cur.mode && wr && rd != 5'd0) begin
      regs[rd] <= wval;
    end
  end

  // Build the result word; a preload reports only the unchanged pc
  always_comb begin
    res_next = '0;
    if (cur.mode) begin
      res_next.next_pc = pc;
    end else begin
      res_next.next_pc        = npc;
      res_next.reg_written    = wr && rd != 5'd0;
      res_next.reg_index      = (wr && rd != 5'd0) ? rd : 5'd0;
      res_next.reg_value      = (wr && rd != 5'd0) ? wval : 32'd0;
      res_next.store_done     = st;
      res_next.store_address  = saddr;
      res_next.store_value    = st ? b : 32'd0;
      res_next.unknown_opcode = unk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  assign status.is_div   = !cur.mode && op == OpReg && f7 == F7Mul &&
                           (f3 == F3Div || f3 == F3Rem) && b != 32'd0;
  assign status.is_mul   = !cur.mode && op == OpReg && f7 == F7Mul &&
                           (f3 == F3Add || f3 == F3Mulh);
  assign status.is_load  = !cur.mode && op == OpLoad;
  assign status.div_done = div_done;

endmodule

// ===== hdl/rv32x_ctrl.sv =====
// Controller state machine: sequences capture, memory, multiply, divide, commit.
// Depends on rv32x_pkg; drives the datapath through dp_cmd_t.
module rv32x_ctrl
  import rv32x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StMem    = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StCommit = 3'd5;
  localparam logic [2:0] StMulB   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Accept a new word when idle and no result is parked
  assign in_ready = (state == StIdle) && !(out_valid && !out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      StIdle: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = StDecode;
        end
      end
      StDecode: begin
        if (status.is_load) begin
          cmd.mem_read = 1'b1;
          state_next = StMem;
        end else if (status.is_mul) begin
          cmd.mul_lo = 1'b1;
          state_next = StMul;
        end else if (status.is_div) begin
          cmd.div_start = 1'b1;
          state_next = StDiv;
        end else begin
          state_next = StCommit;
        end
      end
      StMem:  state_next = StCommit;
      StMul: begin
        cmd.mul_hi = 1'b1;
        state_next = StMulB;
      end
      StMulB: state_next = StCommit;
      StDiv: begin
        if (status.div_done) state_next = StCommit;
      end
      StCommit: begin
        cmd.finish = 1'b1;
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/rv32_subset_instruction_executor.sv =====
// Each word goes from capture through decode to commit; lw adds a memory read state, mul/mulh
// two multiply states, div/rem a divide state that waits for the one-bit-per-cycle divider
// (not for a zero divisor). One word at a time: the next word can be accepted in the cycle
// the result is taken, at the earliest in the cycle the result appears.
// Reset (rst, synchronous): pc = 0x1000, registers cleared; data memory is zeroed by a
// pass over all 1024 words after reset, during which no word is accepted.
module rv32_subset_instruction_executor
  import rv32x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t     cmd;
  dp_cmd_t     dcmd;
  dp_status_t  status;
  logic        cfg_we;
  logic [31:0] start_pc;
  logic        ctl_ready;
  logic        clearing;
  logic [DataAw:0] clr_cnt;
  in_word_t    dp_in;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr[2] == RegStartPc;
  assign prdata = (paddr[2] == RegStartPc) ? start_pc : 32'd0;

  // Walk every data memory address once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (DataAw+1)'(DataWords - 1)) clearing <= 1'b0;
    end
  end

  always_comb begin
    dcmd  = cmd;
    dp_in = in_data;
    if (clearing) begin
      dcmd = '0;
    end
  end

  assign in_ready = ctl_ready && !clearing;

  rv32x_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && !clearing),
    .in_ready  (ctl_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rv32x_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (dp_in),
    .cmd      (dcmd),
    .cfg_we   (cfg_we),
    .cfg_data (pwdata),
    .clr_en   (clearing),
    .clr_addr (clr_cnt[DataAw-1:0]),
    .status   (status),
    .result   (out_data),
    .start_pc (start_pc)
  );

endmodule

// ===== hdl/rv32x_checker.sv =====
// Port-level checker for the executor, bound to the top level.
// Depends on rv32x_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rv32x_checker
  import rv32x_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Result words hold while stalled
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // A store reports no register write and no unknown opcode
  `CHK_IMPLY(a_flags_excl, clk, rst, out_valid && out_data.store_done,
             !out_data.reg_written && !out_data.unknown_opcode)
  // No write reported for x0
  `CHK_IMPLY(a_no_x0, clk, rst, out_valid && out_data.reg_written, out_data.reg_index != 5'd0)
  // Accept never happens while a result is parked
  `CHK_IMPLY(a_no_accept_parked, clk, rst, out_valid && !out_ready, !in_ready)

endmodule

bind rv32_subset_instruction_executor rv32x_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/rv32_subset_instruction_executor_test.sv =====
// Self-checking testbench for the RV32 subset executor: directed and random instruction words.
// Depends on rv32x_pkg for payload structs, opcodes and function codes; drives the block only.
module rv32_subset_instruction_executor_test;
  import rv32x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int ItemsPerPhase = 400;

  // Architectural shadow of the executor and the queue of results it predicts
  class exec_scoreboard;
    logic [31:0] pc;
    logic [31:0] regs [32];
    logic [31:0] mem [DataWords];
    out_word_t   pending [$];
    int          mismatches;
    int          checked;

    function new();
      pc = ResetPc;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void load_start_pc(logic [31:0] value);
      pc = value;
    endfunction

    function logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit want_rem);
      int sa;
      int sb;
      sa = a;
      sb = b;
      if (b == 0) return want_rem ? a : 32'hFFFF_FFFF;
      if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'h0 : a;
      return want_rem ? sa % sb : sa / sb;
    endfunction

    // Execute one word against the shadow state and queue the expected result
    function void note_input(in_word_t w);
      out_word_t   r;
      logic [31:0] ins, a, b, wval, npc;
      logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
      logic [6:0]  op, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic signed [63:0] prod;
      bit          wr, take;
      r = '0;
      if (w.mode) begin
        mem[w.preload_address[DataAw+1:2]] = w.preload_data;
        r.next_pc = pc;
        pending = {pending, r};
        return;
      end
      ins = w.instruction;
      op = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a = regs[ins[19:15]];
      b = regs[ins[24:20]];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      imm_u = {ins[31:12], 12'h0};
      npc = pc + 4;
      wr = 0;
      take = 0;
      wval = '0;
      case (op)
        OpReg: begin
          if (f7 == F7Base) begin
            wr = 1;
            case (f3)
              F3Add:  wval = a + b;
              F3Sll:  wval = a << b[4:0];
              F3Slt:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              F3Sltu: wval = (a < b) ? 32'd1 : 32'd0;
              F3Xor:  wval = a ^ b;
              F3Srl:  wval = a >> b[4:0];
              F3Or:   wval = a | b;
              default: wval = a & b;
            endcase
          end else if (f7 == F7Alt) begin
            if (f3 == F3Add) begin
              wr = 1;
              wval = a - b;
            end else if (f3 == F3Srl) begin
              wr = 1;
              wval = $signed(a) >>> b[4:0];
            end
          end else if (f7 == F7Mul) begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            wr = 1;
            case (f3)
              F3Add:  wval = a * b;
              F3Mulh: wval = prod[63:32];
              F3Div:  wval = signed_divide(a, b, 0);
              F3Rem:  wval = signed_divide(a, b, 1);
              default: wr = 0;
            endcase
          end
        end
        OpImm: if (f3 == F3Add) begin
          wr = 1;
          wval = a + imm_i;
        end
        OpLoad: if (f3 == F3Word) begin
          wr = 1;
          wval = (a + imm_i);
          wval = mem[wval[DataAw+1:2]];
        end
        OpStore: if (f3 == F3Word) begin
          r.store_done = 1;
          r.store_address = a + imm_s;
          r.store_value = b;
          mem[r.store_address[DataAw+1:2]] = b;
        end
        OpBranch: begin
          case (f3)
            F3Beq:  take = (a == b);
            F3Bne:  take = (a != b);
            F3Blt:  take = $signed(a) < $signed(b);
            F3Bge:  take = !($signed(a) < $signed(b));
            F3Bltu: take = a < b;
            F3Bgeu: take = a >= b;
            default: take = 0;
          endcase
          if (take) npc = pc + imm_b;
        end
        OpJal: begin
          wr = 1;
          wval = pc + 4;
          npc = pc + imm_j;
        end
        OpJalr: begin
          wr = 1;
          wval = pc + 4;
          npc = (a + imm_i) & ~32'h1;
        end
        OpAuipc: begin
          wr = 1;
          wval = pc + imm_u;
        end
        OpLui: begin
          wr = 1;
          wval = imm_u;
        end
        default: r.unknown_opcode = 1;
      endcase
      // drop writes to x0
      if (wr && rd != 0) begin
        regs[rd] = wval;
        r.reg_written = 1;
        r.reg_index = rd;
        r.reg_value = wval;
      end
      pc = npc;
      r.next_pc = npc;
      pending = {pending, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.next_pc !== exp.next_pc || got.reg_written !== exp.reg_written ||
          got.reg_index !== exp.reg_index || got.reg_value !== exp.reg_value ||
          got.store_done !== exp.store_done || got.store_address !== exp.store_address ||
          got.store_value !== exp.store_value || got.unknown_opcode !== exp.unknown_opcode)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected pc=%h wr=%b rd=%0d val=%h st=%b sa=%h sv=%h unk=%b",
                   exp.next_pc, exp.reg_written, exp.reg_index, exp.reg_value,
                   exp.store_done, exp.store_address, exp.store_value, exp.unknown_opcode);
          $display("  actual   pc=%h wr=%b rd=%0d val=%h st=%b sa=%h sv=%h unk=%b",
                   got.next_pc, got.reg_written, got.reg_index, got.reg_value,
                   got.store_done, got.store_address, got.store_value, got.unknown_opcode);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  exec_scoreboard sb = new();
  bit steady;
  int stall_cycles;
  int preloads;
  int executes;
  int pc_settings;

  rv32_subset_instruction_executor u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OpReg};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3Word, imm[4:0], OpStore};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBranch};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OpJal};
  endfunction

  // Random instruction, mostly well formed, some raw noise
  function automatic logic [31:0] random_instruction();
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    int pick;
    rd = 5'($urandom_range(0, 31));
    rs1 = 5'($urandom_range(0, 31));
    rs2 = 5'($urandom_range(0, 31));
    imm = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom;
    if (pick < 30) return enc_r(F7Base, rs2, rs1, 3'($urandom), rd);
    if (pick < 36) return enc_r(F7Alt, rs2, rs1, 3'($urandom), rd);
    if (pick < 46) return enc_r(F7Mul, rs2, rs1, 3'($urandom), rd);
    if (pick < 56) return enc_i(imm, rs1, F3Add, rd, OpImm);
    if (pick < 64) begin
      // keep some addresses near zero so loads meet earlier stores
      if ($urandom_range(0, 1)) return enc_i(12'($urandom_range(0, 63) << 2), 5'd0, F3Word, rd,
                                              OpLoad);
      return enc_i(imm, rs1, ($urandom_range(0, 7) == 0) ? 3'($urandom) : F3Word, rd, OpLoad);
    end
    if (pick < 72) begin
      if ($urandom_range(0, 1)) return enc_s(12'($urandom_range(0, 63) << 2), rs2, 5'd0);
      return enc_s(imm, rs2, rs1);
    end
    if (pick < 82) return enc_b(13'($urandom), rs2, rs1, 3'($urandom));
    if (pick < 86) return enc_j(21'($urandom), rd);
    if (pick < 90) return enc_i(imm, rs1, 3'($urandom), rd, OpJalr);
    if (pick < 95) return {20'($urandom_range(0, 32'hFFFFF)), rd, OpAuipc};
    return {20'($urandom_range(0, 32'hFFFFF)), rd, OpLui};
  endfunction

  // Hold valid and payload until accepted, then maybe idle
  task automatic send_word(in_word_t w);
    bit go;
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(negedge clk);
      go = in_ready;
      @(posedge clk);
    end while (!go);
    sb.note_input(w);
    if (w.mode) preloads++;
    else executes++;
    if (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic run(logic [31:0] instruction);
    in_word_t w;
    w.mode = 1'b0;
    w.instruction = instruction;
    w.preload_address = $urandom;
    w.preload_data = $urandom;
    send_word(w);
  endtask

  task automatic preload(logic [31:0] address, logic [31:0] data);
    in_word_t w;
    w.mode = 1'b1;
    w.instruction = $urandom;
    w.preload_address = address;
    w.preload_data = data;
    send_word(w);
  endtask

  // Drop valid and wait for the block to drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegStartPc, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.load_start_pc(value);
    pc_settings++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // Check results and watch for a hang
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("ERROR: no progress for %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] pc_values [5];
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // wait out the memory clear pass
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    write_start_pc(ResetPc);

    // Directed: operand extremes, most operations, division corner cases
    run({20'h80000, 5'd1, OpLui});
    run(enc_i(12'hFFF, 5'd0, F3Add, 5'd2, OpImm));
    run(enc_r(F7Mul, 5'd2, 5'd1, F3Div, 5'd3));
    run(enc_r(F7Mul, 5'd2, 5'd1, F3Rem, 5'd4));
    run(enc_r(F7Mul, 5'd0, 5'd1, F3Div, 5'd5));
    run(enc_r(F7Mul, 5'd0, 5'd1, F3Rem, 5'd6));
    run(enc_r(F7Mul, 5'd2, 5'd2, F3Mulh, 5'd7));
    run(enc_r(F7Mul, 5'd1, 5'd2, F3Add, 5'd8));
    run(enc_r(F7Alt, 5'd2, 5'd1, F3Add, 5'd9));
    run(enc_r(F7Alt, 5'd2, 5'd1, F3Srl, 5'd10));
    run(enc_r(F7Base, 5'd2, 5'd1, F3Slt, 5'd11));
    run(enc_r(F7Base, 5'd2, 5'd1, F3Sltu, 5'd12));
    run(enc_r(F7Base, 5'd2, 5'd2, F3Sll, 5'd13));
    run(enc_r(F7Base, 5'd2, 5'd1, F3Srl, 5'd14));
    run(enc_r(F7Base, 5'd2, 5'd1, F3Xor, 5'd15));
    run(enc_r(F7Base, 5'd2, 5'd1, F3Or, 5'd16));
    run(enc_r(F7Base, 5'd2, 5'd1, F3And, 5'd0));
    run(enc_r(F7Alt, 5'd2, 5'd1, F3Or, 5'd17));
    preload(32'hFFFF_FFFF, 32'hA5A5_5A5A);
    run(enc_s(12'h7FC, 5'd1, 5'd0));
    run(enc_i(12'h7FC, 5'd0, F3Word, 5'd18, OpLoad));
    run(enc_i(12'hFFC, 5'd0, F3Word, 5'd19, OpLoad));
    run(enc_b(13'h1FFE, 5'd1, 5'd1, F3Beq));
    run(enc_j(21'h0FFFFE, 5'd31));
    run(enc_i(12'h801, 5'd2, F3Sltu, 5'd20, OpJalr));
    run({20'hFFFFF, 5'd21, OpAuipc});
    run(32'hFFFF_FFFF);
    drain();

    // Random phases, each under its own start pc; drained between phases
    pc_values[0] = 32'hFFFF_FFF0;
    pc_values[1] = 32'h0000_0000;
    pc_values[2] = 32'hFFFF_FFFF;
    pc_values[3] = $urandom;
    pc_values[4] = ResetPc;
    for (int phase = 0; phase < 5; phase++) begin
      write_start_pc(pc_values[phase]);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        steady = (phase == 2) && (n >= 100) && (n < 350);
        if ($urandom_range(0, 99) < 7) begin
          if ($urandom_range(0, 1)) preload($urandom_range(0, 255) << 2, $urandom);
          else preload($urandom, $urandom);
        end else begin
          run(random_instruction());
        end
      end
      steady = 0;
      drain();
    end

    if (sb.pending.size() != 0) sb.mismatches++;
    $display("Ran %0d instructions and %0d preloads under %0d start pc settings.",
             executes, preloads, pc_settings);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rv32x_pkg.sv
hdl/rv32x_divider.sv
hdl/rv32x_datapath.sv
hdl/rv32x_ctrl.sv
hdl/rv32_subset_instruction_executor.sv
hdl/rv32x_checker.sv
verif/rv32_subset_instruction_executor_test.sv
